@@ rtl/lmc_pkg.sv @@
// ----------------------------------------------------------------------------
// lmc_pkg
// Shared types and constants for the LED matrix chain frame controller.
// ----------------------------------------------------------------------------
package lmc_pkg;

    localparam logic [2:0] OP_INIT    = 3'd0;
    localparam logic [2:0] OP_CLEAR   = 3'd1;
    localparam logic [2:0] OP_DRAW    = 3'd2;
    localparam logic [2:0] OP_ROW     = 3'd3;
    localparam logic [2:0] OP_REFRESH = 3'd4;
    localparam logic [2:0] OP_BRIGHT  = 3'd5;

    localparam logic [7:0] ADDR_DECODE    = 8'h09;
    localparam logic [7:0] ADDR_INTENSITY = 8'h0A;
    localparam logic [7:0] ADDR_SCANLIM   = 8'h0B;
    localparam logic [7:0] ADDR_SHUTDOWN  = 8'h0C;
    localparam logic [7:0] ADDR_DISPTEST  = 8'h0F;

    localparam logic [2:0] GRP_SHUTDOWN = 3'd0;
    localparam logic [2:0] GRP_DECODE   = 3'd1;
    localparam logic [2:0] GRP_SCANLIM  = 3'd2;
    localparam logic [2:0] GRP_INTENS   = 3'd3;
    localparam logic [2:0] GRP_DISPTEST = 3'd4;
    localparam logic [2:0] GRP_BRIGHT   = 3'd5;

    localparam logic [3:0] BRIGHT_MAX = 4'd15;
    localparam logic [2:0] ROW_LAST   = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_SETUP   = 4'b0010,
        S_PIXWR   = 4'b0100,
        S_REFRESH = 4'b1000
    } t_state;

    typedef struct packed {
        logic       valid;
        logic       use_const;
        logic [7:0] addr;
        logic [7:0] data;
        logic       latch;
        logic       last;
    } t_word_a;

    function automatic logic [7:0] setup_addr(input logic [2:0] grp);
        logic [7:0] a;
        unique case (grp)
            GRP_SHUTDOWN: a = ADDR_SHUTDOWN;
            GRP_DECODE:   a = ADDR_DECODE;
            GRP_SCANLIM:  a = ADDR_SCANLIM;
            GRP_DISPTEST: a = ADDR_DISPTEST;
            default:      a = ADDR_INTENSITY;
        endcase
        return a;
    endfunction

    function automatic logic [7:0] setup_data(input logic [2:0] grp);
        logic [7:0] d;
        unique case (grp)
            GRP_SHUTDOWN: d = 8'h01;
            GRP_SCANLIM:  d = 8'h07;
            GRP_INTENS:   d = 8'h01;
            default:      d = 8'h00;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/lmc_frame_mem.sv @@
// ----------------------------------------------------------------------------
// lmc_frame_mem
// Frame buffer memory with a registered read and per-entry valid
// bits; an entry that is not valid reads as zero.
// ----------------------------------------------------------------------------
module lmc_frame_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [7:0]       r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end else if (i_clear) begin
            r_valid <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_valid[i_raddr] ? r_mem[i_raddr] : 8'h00;
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/lmc_ctrl.sv @@
// ----------------------------------------------------------------------------
// lmc_ctrl
// Operation sequencer: decodes commands, runs the read-modify-write of a
// pixel, and walks the setup groups and the refresh scan.
// ----------------------------------------------------------------------------
module lmc_ctrl #(
    parameter int MODULES = 4,
    parameter int AW      = 5,
    parameter int MW      = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  logic [2:0]      i_operation,
    input  logic [5:0]      i_pixel_x,
    input  logic [3:0]      i_pixel_y,
    input  logic            i_pixel_on,
    input  logic [1:0]      i_module_index,
    input  logic [2:0]      i_row_index,
    input  logic [7:0]      i_row_byte,
    input  logic [7:0]      i_brightness,
    output logic            o_clear,
    output logic            o_we,
    output logic [AW-1:0]   o_waddr,
    output logic [7:0]      o_wdata,
    output logic            o_re,
    output logic [AW-1:0]   o_raddr,
    input  logic [7:0]      i_rdata,
    output lmc_pkg::t_word_a o_word
);

    lmc_pkg::t_state  r_state, n_state;
    logic [2:0]       r_grp, n_grp;
    logic [2:0]       r_grp_end, n_grp_end;
    logic             r_then_ref, n_then_ref;
    logic [3:0]       r_bright, n_bright;
    logic [MW-1:0]    r_mod, n_mod;
    logic [2:0]       r_row, n_row;
    logic [7:0]       r_mask, n_mask;
    logic             r_on, n_on;
    logic [AW-1:0]    r_widx, n_widx;
    lmc_pkg::t_word_a r_word, n_word;

    logic             w_accept;
    logic             w_mod_last;
    logic             w_pix_ok;
    logic             w_row_ok;
    logic [5:0]       w_pix_full;
    logic [4:0]       w_row_full;
    logic [MW+2:0]    w_scan_full;

    assign w_accept    = i_start && (r_state == lmc_pkg::S_IDLE);
    assign w_mod_last  = (r_mod == MW'(MODULES - 1));
    assign w_pix_ok    = (i_pixel_x[5:3] < 3'(MODULES)) && !i_pixel_y[3];
    assign w_row_ok    = ({1'b0, i_module_index} < 3'(MODULES));
    assign w_pix_full  = {i_pixel_x[5:3], i_pixel_y[2:0]};
    assign w_row_full  = {i_module_index, i_row_index};
    assign w_scan_full = {r_mod, r_row};

    always_comb begin
        n_state    = r_state;
        n_grp      = r_grp;
        n_grp_end  = r_grp_end;
        n_then_ref = r_then_ref;
        n_bright   = r_bright;
        n_mod      = r_mod;
        n_row      = r_row;
        n_mask     = r_mask;
        n_on       = r_on;
        n_widx     = r_widx;
        n_word     = '0;
        o_clear    = 1'b0;
        o_we       = 1'b0;
        o_waddr    = w_row_full[AW-1:0];
        o_wdata    = i_row_byte;
        o_re       = 1'b0;
        o_raddr    = w_scan_full[AW-1:0];

        unique case (r_state)
            lmc_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_mod = '0;
                    n_row = '0;
                    case (i_operation)
                        lmc_pkg::OP_INIT: begin
                            o_clear    = 1'b1;
                            n_grp      = lmc_pkg::GRP_SHUTDOWN;
                            n_grp_end  = lmc_pkg::GRP_DISPTEST;
                            n_then_ref = 1'b1;
                            n_state    = lmc_pkg::S_SETUP;
                        end
                        lmc_pkg::OP_CLEAR: begin
                            o_clear = 1'b1;
                            n_state = lmc_pkg::S_REFRESH;
                        end
                        lmc_pkg::OP_DRAW: begin
                            if (w_pix_ok) begin
                                o_re    = 1'b1;
                                o_raddr = w_pix_full[AW-1:0];
                                n_widx  = w_pix_full[AW-1:0];
                                n_mask  = 8'h80 >> i_pixel_x[2:0];
                                n_on    = i_pixel_on;
                                n_state = lmc_pkg::S_PIXWR;
                            end
                        end
                        lmc_pkg::OP_ROW: begin
                            o_we = w_row_ok;
                        end
                        lmc_pkg::OP_REFRESH: begin
                            n_state = lmc_pkg::S_REFRESH;
                        end
                        lmc_pkg::OP_BRIGHT: begin
                            n_grp      = lmc_pkg::GRP_BRIGHT;
                            n_grp_end  = lmc_pkg::GRP_BRIGHT;
                            n_then_ref = 1'b0;
                            n_bright   = (i_brightness > 8'(lmc_pkg::BRIGHT_MAX))
                                         ? lmc_pkg::BRIGHT_MAX : i_brightness[3:0];
                            n_state    = lmc_pkg::S_SETUP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            lmc_pkg::S_SETUP: begin
                n_word.valid     = 1'b1;
                n_word.use_const = 1'b1;
                n_word.addr      = lmc_pkg::setup_addr(r_grp);
                n_word.data      = (r_grp == lmc_pkg::GRP_BRIGHT)
                                   ? {4'h0, r_bright} : lmc_pkg::setup_data(r_grp);
                n_word.latch     = w_mod_last;
                n_word.last      = w_mod_last && (r_grp == r_grp_end) && !r_then_ref;
                if (w_mod_last) begin
                    n_mod = '0;
                    if (r_grp == r_grp_end) begin
                        n_row   = '0;
                        n_state = r_then_ref ? lmc_pkg::S_REFRESH : lmc_pkg::S_IDLE;
                    end else begin
                        n_grp = r_grp + 3'd1;
                    end
                end else begin
                    n_mod = r_mod + MW'(1);
                end
            end
            lmc_pkg::S_PIXWR: begin
                o_we    = 1'b1;
                o_waddr = r_widx;
                o_wdata = r_on ? (i_rdata | r_mask) : (i_rdata & ~r_mask);
                n_state = lmc_pkg::S_IDLE;
            end
            lmc_pkg::S_REFRESH: begin
                o_re             = 1'b1;
                n_word.valid     = 1'b1;
                n_word.use_const = 1'b0;
                n_word.addr      = {5'd0, r_row} + 8'd1;
                n_word.latch     = w_mod_last;
                n_word.last      = w_mod_last && (r_row == lmc_pkg::ROW_LAST);
                if (w_mod_last) begin
                    n_mod = '0;
                    if (r_row == lmc_pkg::ROW_LAST) begin
                        n_state = lmc_pkg::S_IDLE;
                    end else begin
                        n_row = r_row + 3'd1;
                    end
                end else begin
                    n_mod = r_mod + MW'(1);
                end
            end
            default: begin
                n_state = lmc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lmc_pkg::S_IDLE;
            r_word.valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_word  <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp      <= n_grp;
        r_grp_end  <= n_grp_end;
        r_then_ref <= n_then_ref;
        r_bright   <= n_bright;
        r_mod      <= n_mod;
        r_row      <= n_row;
        r_mask     <= n_mask;
        r_on       <= n_on;
        r_widx     <= n_widx;
    end

    assign o_busy = (r_state != lmc_pkg::S_IDLE);
    assign o_word = r_word;

endmodule

@@ rtl/led_matrix_chain_frame_controller.sv @@
// ----------------------------------------------------------------------------
// led_matrix_chain_frame_controller
// Frame buffer for a chain of 8x8 LED modules that turns commands into
// 16-bit driver command words.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// command   in         start && !busy      operation, pixel, row and level fields
// result    out        o_strobe, no stall   command_word, latch_after, last_word
//
// Draw pixel holds busy through its write-back state (read, then write back); row write
// does not raise busy. Refresh issues one frame buffer read per cycle, giving
// 8*MODULES words; init adds 5*MODULES setup words first. Words pass through
// the sequencer word register and the output register and stream one per
// cycle within a command. Reset clears the sequencer and the valid bits of the
// frame buffer. The receiver cannot stall the result stream.
// ----------------------------------------------------------------------------
module led_matrix_chain_frame_controller #(
    parameter int MODULES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_operation,
    input  logic [5:0]  i_pixel_x,
    input  logic [3:0]  i_pixel_y,
    input  logic        i_pixel_on,
    input  logic [1:0]  i_module_index,
    input  logic [2:0]  i_row_index,
    input  logic [7:0]  i_row_byte,
    input  logic [7:0]  i_brightness,
    output logic        o_strobe,
    output logic [15:0] o_command_word,
    output logic        o_latch_after,
    output logic        o_last_word
);

    localparam int DEPTH = MODULES * 8;
    localparam int AW    = $clog2(DEPTH);
    localparam int MW    = (MODULES > 1) ? $clog2(MODULES) : 1;

    logic             w_clear;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [7:0]       w_wdata;
    logic             w_re;
    logic [AW-1:0]    w_raddr;
    logic [7:0]       w_rdata;
    lmc_pkg::t_word_a w_word;

    logic             r_strobe;
    logic [15:0]      r_command_word;
    logic             r_latch_after;
    logic             r_last_word;

    lmc_ctrl #(
        .MODULES (MODULES),
        .AW      (AW),
        .MW      (MW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_operation    (i_operation),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_pixel_on     (i_pixel_on),
        .i_module_index (i_module_index),
        .i_row_index    (i_row_index),
        .i_row_byte     (i_row_byte),
        .i_brightness   (i_brightness),
        .o_clear        (w_clear),
        .o_we           (w_we),
        .o_waddr        (w_waddr),
        .o_wdata        (w_wdata),
        .o_re           (w_re),
        .o_raddr        (w_raddr),
        .i_rdata        (w_rdata),
        .o_word         (w_word)
    );

    lmc_frame_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_clear),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_word.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_command_word <= {w_word.addr, w_word.use_const ? w_word.data : w_rdata};
        r_latch_after  <= w_word.latch;
        r_last_word    <= w_word.last;
    end

    assign o_strobe       = r_strobe;
    assign o_command_word = r_command_word;
    assign o_latch_after  = r_latch_after;
    assign o_last_word    = r_last_word;

endmodule

@@ rtl/lmc_chk.sv @@
// ----------------------------------------------------------------------------
// lmc_chk
// Port-level checks of the result stream of the frame controller.
// ----------------------------------------------------------------------------
module lmc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        busy,
    input logic        o_strobe,
    input logic [15:0] o_command_word,
    input logic        o_latch_after,
    input logic        o_last_word
);

    a_last_ends_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last_word |-> o_latch_after)
        else $error("final beat does not end a group");

    a_group_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_latch_after |=> o_strobe)
        else $error("group broken by an idle cycle");

    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_command_word[15:12] == 4'h0))
        else $error("driver register address out of range");

    a_intensity_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_command_word[15:8] == 8'h0A) |-> (o_command_word[7:4] == 4'h0))
        else $error("intensity above maximum");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe && !busy)
        else $error("activity straight after reset");

endmodule

bind led_matrix_chain_frame_controller lmc_chk u_lmc_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .busy           (busy),
    .o_strobe       (o_strobe),
    .o_command_word (o_command_word),
    .o_latch_after  (o_latch_after),
    .o_last_word    (o_last_word)
);

@@ bench/led_matrix_chain_frame_controller_tb.sv @@
// ----------------------------------------------------------------------------
// led_matrix_chain_frame_controller_tb
// Self-checking bench for the LED matrix chain frame controller. A directed
// pass covers every command, the panel edges, ignored draws, the brightness
// ceiling and the spare operation codes. A random pass then follows with
// idle gaps on the command side. A scoreboard keeps its own copy of the
// frame buffer and checks every command word, in order, field by field.
// ----------------------------------------------------------------------------
module led_matrix_chain_frame_controller_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         MODULES    = 4;
    localparam int         PANEL_ROWS = 8 * MODULES;
    localparam logic [2:0] OP_SPARE6  = 3'd6;
    localparam logic [2:0] OP_SPARE7  = 3'd7;
    localparam int         RANDOM_CMDS = 190;

    typedef struct packed {
        logic [15:0] command_word;
        logic        latch_after;
        logic        last_word;
    } t_chain_word;

    class frame_scoreboard;
        logic [7:0]  frame_image [PANEL_ROWS];
        t_chain_word pending_words [$];
        int          mismatches;

        function new();
            mismatches = 0;
            blank_frame();
        endfunction

        function void blank_frame();
            foreach (frame_image[i]) frame_image[i] = 8'h00;
        endfunction

        function void queue_word(logic [7:0] addr, logic [7:0] data, logic latch);
            t_chain_word w;
            w.command_word = {addr, data};
            w.latch_after  = latch;
            w.last_word    = 1'b0;
            pending_words.push_back(w);
        endfunction

        function void queue_group(logic [7:0] addr, logic [7:0] data);
            for (int m = 0; m < MODULES; m++) begin
                queue_word(addr, data, m == MODULES - 1);
            end
        endfunction

        function void queue_refresh();
            for (int row = 0; row < 8; row++) begin
                for (int m = 0; m < MODULES; m++) begin
                    queue_word(8'(row + 1), frame_image[m * 8 + row], m == MODULES - 1);
                end
            end
        endfunction

        function void note_command(logic [2:0] op, logic [5:0] px, logic [3:0] py,
                                   logic on, logic [1:0] mi, logic [2:0] ri,
                                   logic [7:0] rb, logic [7:0] br);
            int         before_count;
            int         idx;
            logic [7:0] mask;
            before_count = pending_words.size();
            case (op)
                lmc_pkg::OP_INIT: begin
                    queue_group(lmc_pkg::ADDR_SHUTDOWN, 8'h01);
                    queue_group(lmc_pkg::ADDR_DECODE, 8'h00);
                    queue_group(lmc_pkg::ADDR_SCANLIM, 8'h07);
                    queue_group(lmc_pkg::ADDR_INTENSITY, 8'h01);
                    queue_group(lmc_pkg::ADDR_DISPTEST, 8'h00);
                    blank_frame();
                    queue_refresh();
                end
                lmc_pkg::OP_CLEAR: begin
                    blank_frame();
                    queue_refresh();
                end
                lmc_pkg::OP_DRAW: begin
                    if (px < PANEL_ROWS && py < 8) begin
                        idx  = (px >> 3) * 8 + py;
                        mask = 8'h80 >> px[2:0];
                        if (on) begin
                            frame_image[idx] = frame_image[idx] | mask;
                        end else begin
                            frame_image[idx] = frame_image[idx] & ~mask;
                        end
                    end
                end
                lmc_pkg::OP_ROW: begin
                    if (mi < MODULES) frame_image[mi * 8 + ri] = rb;
                end
                lmc_pkg::OP_REFRESH: begin
                    queue_refresh();
                end
                lmc_pkg::OP_BRIGHT: begin
                    queue_group(lmc_pkg::ADDR_INTENSITY,
                                (br > {4'd0, lmc_pkg::BRIGHT_MAX})
                                ? {4'd0, lmc_pkg::BRIGHT_MAX} : br);
                end
                default: begin
                end
            endcase
            if (pending_words.size() > before_count) begin
                pending_words[pending_words.size() - 1].last_word = 1'b1;
            end
        endfunction

        function void check_word(logic [15:0] cw, logic latch, logic last);
            t_chain_word exp_word;
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h latch %b last %b",
                         $time, cw, latch, last);
                mismatches++;
                return;
            end
            exp_word = pending_words.pop_front();
            if (cw !== exp_word.command_word) begin
                $display("%0t: command_word expected %h actual %h",
                         $time, exp_word.command_word, cw);
                mismatches++;
            end
            if (latch !== exp_word.latch_after) begin
                $display("%0t: latch_after expected %b actual %b",
                         $time, exp_word.latch_after, latch);
                mismatches++;
            end
            if (last !== exp_word.last_word) begin
                $display("%0t: last_word expected %b actual %b",
                         $time, exp_word.last_word, last);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_operation;
    logic [5:0]  i_pixel_x;
    logic [3:0]  i_pixel_y;
    logic        i_pixel_on;
    logic [1:0]  i_module_index;
    logic [2:0]  i_row_index;
    logic [7:0]  i_row_byte;
    logic [7:0]  i_brightness;
    logic        o_strobe;
    logic [15:0] o_command_word;
    logic        o_latch_after;
    logic        o_last_word;

    frame_scoreboard sb;

    led_matrix_chain_frame_controller #(
        .MODULES(MODULES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_pixel_on     (i_pixel_on),
        .i_module_index (i_module_index),
        .i_row_index    (i_row_index),
        .i_row_byte     (i_row_byte),
        .i_brightness   (i_brightness),
        .o_strobe       (o_strobe),
        .o_command_word (o_command_word),
        .o_latch_after  (o_latch_after),
        .o_last_word    (o_last_word)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            sb.check_word(o_command_word, o_latch_after, o_last_word);
        end
    end

    task automatic send_command(logic [2:0] op, logic [5:0] px, logic [3:0] py,
                                logic on, logic [1:0] mi, logic [2:0] ri,
                                logic [7:0] rb, logic [7:0] br);
        @(negedge i_clk);
        start          = 1'b1;
        i_operation    = op;
        i_pixel_x      = px;
        i_pixel_y      = py;
        i_pixel_on     = on;
        i_module_index = mi;
        i_row_index    = ri;
        i_row_byte     = rb;
        i_brightness   = br;
        do begin
            @(posedge i_clk);
        end while (busy);
        sb.note_command(op, px, py, on, mi, ri, rb, br);
    endtask

    task automatic pause_commands(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start = 1'b0;
        end
    endtask

    task automatic send_random_command();
        logic [2:0] op;
        logic [5:0] px;
        logic [3:0] py;
        int         pick;
        pick = $urandom_range(0, 99);
        px   = 6'($urandom);
        py   = 4'($urandom);
        if (pick < 3) begin
            op = lmc_pkg::OP_INIT;
        end else if (pick < 10) begin
            op = lmc_pkg::OP_CLEAR;
        end else if (pick < 45) begin
            op = lmc_pkg::OP_DRAW;
            if ($urandom_range(0, 99) < 80) begin
                px = 6'($urandom_range(0, PANEL_ROWS - 1));
                py = 4'($urandom_range(0, 7));
            end
        end else if (pick < 70) begin
            op = lmc_pkg::OP_ROW;
        end else if (pick < 80) begin
            op = lmc_pkg::OP_REFRESH;
        end else if (pick < 94) begin
            op = lmc_pkg::OP_BRIGHT;
        end else begin
            op = ($urandom_range(0, 1) != 0) ? OP_SPARE6 : OP_SPARE7;
        end
        send_command(op, px, py, 1'($urandom), 2'($urandom), 3'($urandom),
                     8'($urandom), 8'($urandom));
    endtask

    initial begin
        sb             = new();
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_operation    = lmc_pkg::OP_INIT;
        i_pixel_x      = '0;
        i_pixel_y      = '0;
        i_pixel_on     = 1'b0;
        i_module_index = '0;
        i_row_index    = '0;
        i_row_byte     = '0;
        i_brightness   = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_command(lmc_pkg::OP_INIT,    6'd0,  4'd0,  1'b0, 2'd0, 3'd0, 8'h00, 8'h00);
        send_command(lmc_pkg::OP_DRAW,    6'd0,  4'd0,  1'b1, 2'd0, 3'd0, 8'h00, 8'h00);
        send_command(lmc_pkg::OP_DRAW,    6'd31, 4'd7,  1'b1, 2'd0, 3'd0, 8'h00, 8'h00);
        send_command(lmc_pkg::OP_DRAW,    6'd32, 4'd0,  1'b1, 2'd0, 3'd0, 8'h00, 8'h00);
        send_command(lmc_pkg::OP_DRAW,    6'd63, 4'd15, 1'b1, 2'd3, 3'd7, 8'hFF, 8'hFF);
        send_command(lmc_pkg::OP_DRAW,    6'd5,  4'd8,  1'b1, 2'd0, 3'd0, 8'h00, 8'h00);
        send_command(lmc_pkg::OP_ROW,     6'd0,  4'd0,  1'b0, 2'd3, 3'd7, 8'hFF, 8'h00);
        send_command(lmc_pkg::OP_ROW,     6'd0,  4'd0,  1'b0, 2'd0, 3'd0, 8'hA5, 8'h00);
        send_command(lmc_pkg::OP_REFRESH, 6'd0,  4'd0,  1'b0, 2'd0, 3'd0, 8'h00, 8'h00);
        send_command(lmc_pkg::OP_DRAW,    6'd0,  4'd0,  1'b0, 2'd0, 3'd0, 8'h00, 8'h00);
        send_command(lmc_pkg::OP_ROW,     6'd0,  4'd0,  1'b0, 2'd1, 3'd3, 8'h00, 8'h00);
        send_command(lmc_pkg::OP_REFRESH, 6'd0,  4'd0,  1'b0, 2'd0, 3'd0, 8'h00, 8'h00);
        send_command(lmc_pkg::OP_BRIGHT,  6'd0,  4'd0,  1'b0, 2'd0, 3'd0, 8'h00, 8'd0);
        send_command(lmc_pkg::OP_BRIGHT,  6'd0,  4'd0,  1'b0, 2'd0, 3'd0, 8'h00, 8'd15);
        send_command(lmc_pkg::OP_BRIGHT,  6'd0,  4'd0,  1'b0, 2'd0, 3'd0, 8'h00, 8'd16);
        send_command(lmc_pkg::OP_BRIGHT,  6'd0,  4'd0,  1'b0, 2'd0, 3'd0, 8'h00, 8'd255);
        send_command(OP_SPARE6,           6'd63, 4'd15, 1'b1, 2'd3, 3'd7, 8'hFF, 8'hFF);
        send_command(OP_SPARE7,           6'd0,  4'd0,  1'b0, 2'd0, 3'd0, 8'h00, 8'h00);
        send_command(lmc_pkg::OP_CLEAR,   6'd0,  4'd0,  1'b0, 2'd0, 3'd0, 8'h00, 8'h00);
        send_command(lmc_pkg::OP_REFRESH, 6'd0,  4'd0,  1'b0, 2'd0, 3'd0, 8'h00, 8'h00);

        // Random commands 70 to 150 are sent back to back with no idle gaps.
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            if ((n < 70 || n > 150) && $urandom_range(0, 99) < 13) begin
                pause_commands($urandom_range(1, 4));
            end
            send_random_command();
        end
        pause_commands(1);

        while (sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
